### hdl/nearest_reference_detection_matcher_top_macros.svh
// Assertion macros for the nearest reference matcher.
// Used by the modules that carry concurrent assertions.
`ifndef NEAREST_REFERENCE_DETECTION_MATCHER_TOP_MACROS_SVH
`define NEAREST_REFERENCE_DETECTION_MATCHER_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define NRM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define NRM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

### hdl/nrm_pkg.sv
// Package for the nearest reference matcher: payload types, codes, sizes.
// No dependencies.
package nrm_pkg;
    localparam int MaxRefs = 256;
    localparam int IdxBits = $clog2(MaxRefs);
    localparam int CntBits = $clog2(MaxRefs + 1);
    localparam int CoordBits = 24;
    localparam int SqBits = 2 * CoordBits + 2;
    localparam logic [23:0] CounterMax = 24'hFFFFFF;

    typedef enum logic [2:0] {
        OUT_STORED = 3'd0,
        OUT_FULL = 3'd1,
        OUT_DISCARDED = 3'd2,
        OUT_FALSE_POS = 3'd3,
        OUT_NEW_MATCH = 3'd4,
        OUT_DUPLICATE = 3'd5
    } outcome_t;

    localparam logic OP_STORE = 1'b0;

    typedef struct packed {
        logic opcode;
        logic signed [CoordBits-1:0] pos_x;
        logic signed [CoordBits-1:0] pos_y;
        logic signed [CoordBits-1:0] pos_z;
        logic [15:0] score;
    } in_item_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] nearest_index;
        logic [23:0] matched_total;
        logic [23:0] false_positive_total;
        logic [23:0] discarded_total;
        logic [8:0] reference_total;
    } out_item_t;

    // queued command from front to back
    typedef struct packed {
        logic is_store;
        logic [3*CoordBits-1:0] pos;
        logic [15:0] score;
    } cmd_t;

    localparam int RefWidth = 3 * CoordBits;
endpackage

### hdl/nrm_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module nrm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/nrm_front.sv
// Front part: takes input transfers, biases coordinates, queues commands.
// Depends on nrm_pkg.
module nrm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  nrm_pkg::in_item_t in_item,
    output logic             cmd_valid,
    input  logic             cmd_take,
    output nrm_pkg::cmd_t    cmd
);
    import nrm_pkg::*;

    localparam int QDepth = 2;

    cmd_t q_reg [QDepth];
    logic [0:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;
    cmd_t fresh;

    assign in_stall = (cnt_reg == 2'(QDepth));
    assign push = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_reg];

    // offset binary keeps order, so the back end uses unsigned differences
    always_comb
    begin
        fresh.is_store = (in_item.opcode == OP_STORE);
        fresh.pos = {in_item.pos_x ^ {1'b1, {(CoordBits-1){1'b0}}},
                     in_item.pos_y ^ {1'b1, {(CoordBits-1){1'b0}}},
                     in_item.pos_z ^ {1'b1, {(CoordBits-1){1'b0}}}};
        fresh.score = in_item.score;
    end

    always_comb
    begin
        wr_next = push ? wr_reg + 1'b1 : wr_reg;
        rd_next = (cmd_valid && cmd_take) ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(cmd_valid && cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= fresh;
        end
    end
endmodule

### hdl/nrm_back.sv
// Back part: stores references, runs the nearest search, classifies.
// Depends on nrm_pkg, nrm_ram and the assertion macro header.
`include "nearest_reference_detection_matcher_top_macros.svh"
module nrm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  nrm_pkg::cmd_t     cmd,
    input  logic [22:0]       dist_limit,
    input  logic [15:0]       score_threshold,
    output logic              out_valid,
    input  logic              out_stall,
    output nrm_pkg::out_item_t out_item
);
    import nrm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_DIFF  = 7'b0000100,
        S_SQ    = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_FLAG  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CntBits-1:0] ref_cnt_reg;
    logic [MaxRefs-1:0] flags_reg;
    logic [23:0] match_cnt_reg, fp_cnt_reg, disc_cnt_reg;
    cmd_t cur_reg;
    logic [CntBits-1:0] scan_reg;     // address issued to the RAM
    logic [CntBits-1:0] rd_idx_reg;   // index of data leaving the RAM
    logic [CntBits-1:0] pipe_idx_reg; // index of data in diff stage
    logic [CntBits-1:0] sq_idx_reg, sum_idx_reg;
    logic rd_v_reg, df_v_reg, sq_v_reg, sm_v_reg;
    logic [CoordBits-1:0] dx_reg, dy_reg, dz_reg;
    logic [2*CoordBits-1:0] sx_reg, sy_reg, sz_reg;
    logic [SqBits-1:0] sum_reg, best_reg;
    logic [IdxBits-1:0] best_idx_reg;
    logic [2*CoordBits-1:0] limit_reg;
    logic best_v_reg;
    out_item_t out_reg;
    logic out_v_reg;
    logic ram_written_reg, searched_reg;
    logic [2:0] verdict_reg;

    logic ram_we;
    logic [RefWidth-1:0] ram_rdata;

    nrm_ram #(.Width(RefWidth), .Depth(MaxRefs)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ref_cnt_reg[IdxBits-1:0]),
        .wdata (cmd.pos),
        .raddr (scan_reg[IdxBits-1:0]),
        .rdata (ram_rdata)
    );

    function automatic logic [CoordBits-1:0] adiff(input logic [CoordBits-1:0] a,
                                                  input logic [CoordBits-1:0] b);
        adiff = (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [23:0] sat(input logic [23:0] c);
        sat = (c == CounterMax) ? c : c + 24'd1;
    endfunction

    logic idle_take;
    assign idle_take = (state_reg == S_IDLE) && cmd_valid && !out_v_reg;
    assign cmd_take = idle_take;
    assign ram_we = idle_take && cmd.is_store && (ref_cnt_reg != CntBits'(MaxRefs));
    assign out_valid = out_v_reg;
    assign out_item = out_reg;

    logic scan_done;
    assign scan_done = !rd_v_reg && !df_v_reg && !sq_v_reg && !sm_v_reg
                       && (scan_reg == ref_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (idle_take && !cmd.is_store && (cmd.score > score_threshold)
                    && (ref_cnt_reg != '0))
                begin
                    state_next = S_READ;
                end
                else if (idle_take)
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                if (scan_done)
                begin
                    state_next = S_FLAG;
                end
            end
            S_FLAG: state_next = S_OUT;
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            S_DIFF, S_SQ, S_SUM: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ref_cnt_reg <= '0;
            flags_reg <= '0;
            match_cnt_reg <= '0;
            fp_cnt_reg <= '0;
            disc_cnt_reg <= '0;
            out_v_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            df_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
            sm_v_reg <= 1'b0;
            best_v_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_v_reg && !out_stall)
            begin
                out_v_reg <= 1'b0;
            end
            // pipeline valid chain of the search
            rd_v_reg <= (state_reg == S_READ) && (scan_reg != ref_cnt_reg);
            df_v_reg <= rd_v_reg;
            sq_v_reg <= df_v_reg;
            sm_v_reg <= sq_v_reg;
            if (state_reg == S_READ && scan_reg != ref_cnt_reg)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (idle_take)
            begin
                scan_reg <= '0;
                best_v_reg <= 1'b0;
                if (cmd.is_store)
                begin
                    if (ref_cnt_reg != CntBits'(MaxRefs))
                    begin
                        ref_cnt_reg <= ref_cnt_reg + 1'b1;
                    end
                end
                else if (cmd.score <= score_threshold)
                begin
                    disc_cnt_reg <= sat(disc_cnt_reg);
                end
                else if (ref_cnt_reg == '0)
                begin
                    fp_cnt_reg <= sat(fp_cnt_reg);
                end
            end
            if (sm_v_reg)
            begin
                best_v_reg <= 1'b1;
            end
            if (state_reg == S_FLAG)
            begin
                if ({{(SqBits-2*CoordBits){1'b0}}, limit_reg} < best_reg)
                begin
                    fp_cnt_reg <= sat(fp_cnt_reg);
                end
                else if (!flags_reg[best_idx_reg])
                begin
                    flags_reg[best_idx_reg] <= 1'b1;
                    match_cnt_reg <= sat(match_cnt_reg);
                end
            end
            if (state_reg == S_OUT)
            begin
                out_v_reg <= 1'b1;
            end
        end
    end

    // datapath registers, one multiplier per axis between registers
    always_ff @(posedge clk)
    begin
        if (idle_take)
        begin
            cur_reg <= cmd;
            limit_reg <= (2*CoordBits)'(dist_limit) * (2*CoordBits)'(dist_limit);
        end
        rd_idx_reg <= scan_reg;
        pipe_idx_reg <= rd_idx_reg;
        dx_reg <= adiff(cur_reg.pos[3*CoordBits-1:2*CoordBits],
                        ram_rdata[3*CoordBits-1:2*CoordBits]);
        dy_reg <= adiff(cur_reg.pos[2*CoordBits-1:CoordBits],
                        ram_rdata[2*CoordBits-1:CoordBits]);
        dz_reg <= adiff(cur_reg.pos[CoordBits-1:0], ram_rdata[CoordBits-1:0]);
        sq_idx_reg <= pipe_idx_reg;
        sx_reg <= dx_reg * dx_reg;
        sy_reg <= dy_reg * dy_reg;
        sz_reg <= dz_reg * dz_reg;
        sum_idx_reg <= sq_idx_reg;
        sum_reg <= SqBits'(sx_reg) + SqBits'(sy_reg) + SqBits'(sz_reg);
        if (sm_v_reg && (!best_v_reg || sum_reg < best_reg))
        begin
            best_reg <= sum_reg;
            best_idx_reg <= sum_idx_reg[IdxBits-1:0];
        end
        if (state_reg == S_OUT)
        begin
            out_reg.matched_total <= match_cnt_reg;
            out_reg.false_positive_total <= fp_cnt_reg;
            out_reg.discarded_total <= disc_cnt_reg;
            out_reg.reference_total <= 9'(ref_cnt_reg);
            if (cur_reg.is_store)
            begin
                if (ram_written_reg)
                begin
                    out_reg.outcome <= OUT_STORED;
                    out_reg.nearest_index <= 8'(ref_cnt_reg - 1'b1);
                end
                else
                begin
                    out_reg.outcome <= OUT_FULL;
                    out_reg.nearest_index <= '0;
                end
            end
            else if (cur_reg.score <= score_threshold)
            begin
                out_reg.outcome <= OUT_DISCARDED;
                out_reg.nearest_index <= '0;
            end
            else if (!searched_reg)
            begin
                out_reg.outcome <= OUT_FALSE_POS;
                out_reg.nearest_index <= '0;
            end
            else
            begin
                out_reg.outcome <= verdict_reg;
                out_reg.nearest_index <= 8'(best_idx_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (idle_take)
        begin
            ram_written_reg <= ram_we;
            searched_reg <= 1'b0;
        end
        if (state_reg == S_FLAG)
        begin
            searched_reg <= 1'b1;
            if ({{(SqBits-2*CoordBits){1'b0}}, limit_reg} < best_reg)
            begin
                verdict_reg <= OUT_FALSE_POS;
            end
            else if (!flags_reg[best_idx_reg])
            begin
                verdict_reg <= OUT_NEW_MATCH;
            end
            else
            begin
                verdict_reg <= OUT_DUPLICATE;
            end
        end
    end

    `NRM_ASSERT(a_take_idle, clk, rst_n, cmd_take |-> !out_v_reg, "take with result pending")
    `NRM_ASSERT(a_cnt_max, clk, rst_n, ref_cnt_reg <= CntBits'(MaxRefs), "reference count overflow")
    `NRM_ASSERT(a_out_after, clk, rst_n, (state_reg == S_OUT) |=> out_v_reg, "result not shown")
    `NRM_NEVER(a_take_busy, clk, rst_n, cmd_take && (state_reg != S_IDLE), "take outside idle")
endmodule

### hdl/nearest_reference_detection_matcher_top.sv
// Top level of the nearest reference detection matcher.
// Depends on nrm_pkg, nrm_front and nrm_back.
//
// Input channel in_valid/in_stall/in_item: opcode 0 stores a reference
// point, opcode 1 evaluates a detection. Output channel out_valid /
// out_stall/out_item: one result per input transfer, in order.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 distance limit,
// index 1 score_threshold; other indexes are ignored. Write while idle.
// A store, discard or empty-table detection passes from the queue through
// the S_OUT state into the output register. A searched detection scans
// the N stored references: the back end reads one reference a cycle from
// the reference RAM through a four-stage distance pipeline, then decides
// in S_FLAG. The back end takes the next queued item in the cycle after
// the result transfer, so it takes no new item while a result waits.
// A two-entry queue sits between front and back, so the input keeps
// taking transfers while a result waits on out_stall; when full the
// input stalls. The output register holds its payload while stalled.
// Reset clears the table count, match flags, counters and the registers
// to 256 and 66. The reference RAM needs no clearing pass.
module nearest_reference_detection_matcher_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nrm_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output nrm_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [22:0]        cfg_data
);
    import nrm_pkg::*;

    localparam logic REG_MAX_DIST = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    logic [22:0] max_dist_reg;
    logic [15:0] thresh_reg;
    logic cmd_valid, cmd_take;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= 23'd256;
            thresh_reg <= 16'd66;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_DIST: max_dist_reg <= cfg_data;
                REG_THRESH: thresh_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    nrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    nrm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_take        (cmd_take),
        .cmd             (cmd),
        .dist_limit      (max_dist_reg),
        .score_threshold (thresh_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item)
    );
endmodule

### tb/sv/nearest_reference_detection_matcher_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_reference_detection_matcher_top.
// Depends on nrm_pkg and the matcher RTL; a directed table, then random
// phases under several register settings, checked against a local model.
module nearest_reference_detection_matcher_top_test;
    import nrm_pkg::*;

    localparam logic OpDetect = ~OP_STORE;
    localparam logic RegMaxDist = 1'b0;
    localparam logic RegThreshold = 1'b1;
    localparam int NumPhases = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [22:0] cfg_data = '0;

    nearest_reference_detection_matcher_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Matcher model: reference table, match flags, counters, registers
    // ---------------------------------------------------------------
    logic signed [CoordBits-1:0] ref_x [MaxRefs];
    logic signed [CoordBits-1:0] ref_y [MaxRefs];
    logic signed [CoordBits-1:0] ref_z [MaxRefs];
    bit matched [MaxRefs];
    int unsigned ref_count = 0;
    logic [23:0] match_cnt = '0;
    logic [23:0] fp_cnt = '0;
    logic [23:0] discard_cnt = '0;
    logic [22:0] max_dist = 23'd256;
    logic [15:0] threshold = 16'd66;

    out_item_t expected_results [$];
    bit failed = 1'b0;
    bit quiet = 1'b0;   // no idling on either side

    function automatic logic [23:0] sat_inc(logic [23:0] c);
        return (c == CounterMax) ? c : c + 24'd1;
    endfunction

    function automatic longint dist_sq(in_item_t it, int i);
        longint dx, dy, dz;
        dx = longint'(it.pos_x) - longint'(ref_x[i]);
        dy = longint'(it.pos_y) - longint'(ref_y[i]);
        dz = longint'(it.pos_z) - longint'(ref_z[i]);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Classify one accepted transfer and advance the model state.
    function automatic out_item_t classify_item(in_item_t it);
        out_item_t r;
        longint best, d, lim;
        int near;
        near = 0;
        if (it.opcode == OP_STORE)
        begin
            if (ref_count < MaxRefs)
            begin
                near = ref_count;
                ref_x[ref_count] = it.pos_x;
                ref_y[ref_count] = it.pos_y;
                ref_z[ref_count] = it.pos_z;
                ref_count++;
                r.outcome = OUT_STORED;
            end
            else
                r.outcome = OUT_FULL;
        end
        else if (it.score <= threshold)
        begin
            discard_cnt = sat_inc(discard_cnt);
            r.outcome = OUT_DISCARDED;
        end
        else if (ref_count == 0)
        begin
            fp_cnt = sat_inc(fp_cnt);
            r.outcome = OUT_FALSE_POS;
        end
        else
        begin
            best = dist_sq(it, 0);
            for (int i = 1; i < ref_count; i++)
            begin
                d = dist_sq(it, i);
                if (d < best)
                begin   // first minimum wins on ties
                    best = d;
                    near = i;
                end
            end
            lim = longint'(max_dist) * longint'(max_dist);
            if (best > lim)
            begin
                fp_cnt = sat_inc(fp_cnt);
                r.outcome = OUT_FALSE_POS;
            end
            else if (!matched[near])
            begin
                matched[near] = 1'b1;
                match_cnt = sat_inc(match_cnt);
                r.outcome = OUT_NEW_MATCH;
            end
            else
                r.outcome = OUT_DUPLICATE;
        end
        r.nearest_index = near[7:0];
        r.matched_total = match_cnt;
        r.false_positive_total = fp_cnt;
        r.discarded_total = discard_cnt;
        r.reference_total = ref_count[8:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stall bursts and the result check
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", out_item);
                failed = 1'b1;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_item.outcome !== exp_r.outcome)
                begin
                    $error("outcome: expected %0d, got %0d", exp_r.outcome, out_item.outcome);
                    failed = 1'b1;
                end
                if (out_item.nearest_index !== exp_r.nearest_index)
                begin
                    $error("nearest_index: expected %0d, got %0d",
                           exp_r.nearest_index, out_item.nearest_index);
                    failed = 1'b1;
                end
                if (out_item.matched_total !== exp_r.matched_total)
                begin
                    $error("matched_total: expected %0d, got %0d",
                           exp_r.matched_total, out_item.matched_total);
                    failed = 1'b1;
                end
                if (out_item.false_positive_total !== exp_r.false_positive_total)
                begin
                    $error("false_positive_total: expected %0d, got %0d",
                           exp_r.false_positive_total, out_item.false_positive_total);
                    failed = 1'b1;
                end
                if (out_item.discarded_total !== exp_r.discarded_total)
                begin
                    $error("discarded_total: expected %0d, got %0d",
                           exp_r.discarded_total, out_item.discarded_total);
                    failed = 1'b1;
                end
                if (out_item.reference_total !== exp_r.reference_total)
                begin
                    $error("reference_total: expected %0d, got %0d",
                           exp_r.reference_total, out_item.reference_total);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Present one item, hold it until the transfer, then predict. An idle
    // burst before the item drops valid; otherwise valid stays high.
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_r);
        out_item_t p;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        p = classify_item(it);
        expected_results = {expected_results, (typed ? typed_r : p)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // pulse the write enable, then drop it and update the model copy
    task automatic write_reg(logic idx, logic [22:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == RegMaxDist)
            max_dist = val;
        else
            threshold = val[15:0];
    endtask

    function automatic logic signed [23:0] rand_coord();
        return CoordBits'($urandom());
    endfunction

    // Random item: stores, noise detections, and detections placed around
    // a stored reference so that matches and duplicates happen often.
    function automatic in_item_t random_item();
        in_item_t it;
        int unsigned pick, off;
        int k;
        pick = $urandom_range(0, 99);
        it.score = 16'($urandom());
        if (pick < 20)
        begin
            it.opcode = OP_STORE;
            it.pos_x = rand_coord();
            it.pos_y = rand_coord();
            it.pos_z = rand_coord();
        end
        else if (pick < 32 || ref_count == 0)
        begin
            it.opcode = OpDetect;
            it.pos_x = rand_coord();
            it.pos_y = rand_coord();
            it.pos_z = rand_coord();
        end
        else
        begin
            it.opcode = OpDetect;
            k = $urandom_range(0, ref_count - 1);
            case ($urandom_range(0, 3))
                0: off = 0;
                1: off = 64;
                2: off = 512;
                default: off = 4096;
            endcase
            it.pos_x = CoordBits'(ref_x[k] + $signed($urandom_range(0, 2 * off)) - $signed(off));
            it.pos_y = CoordBits'(ref_y[k] + $signed($urandom_range(0, 2 * off)) - $signed(off));
            it.pos_z = CoordBits'(ref_z[k] + $signed($urandom_range(0, 2 * off)) - $signed(off));
            // keep most of these above the threshold
            if ($urandom_range(0, 3) != 0 && threshold != 16'hFFFF)
                it.score = 16'($urandom_range(threshold + 1, 16'hFFFF));
        end
        return it;
    endfunction

    typedef struct {
        in_item_t item;
        bit typed;
        out_item_t result;
    } stim_row_t;

    function automatic stim_row_t mk_row(logic op, int x, int y, int z, int sc,
                                         bit typed, outcome_t oc, int idx,
                                         int mt, int fp, int dc, int rt);
        stim_row_t r;
        r.item = '{opcode: op, pos_x: CoordBits'(x), pos_y: CoordBits'(y),
                   pos_z: CoordBits'(z), score: 16'(sc)};
        r.typed = typed;
        r.result = '{outcome: oc, nearest_index: 8'(idx), matched_total: 24'(mt),
                     false_positive_total: 24'(fp), discarded_total: 24'(dc),
                     reference_total: 9'(rt)};
        return r;
    endfunction

    localparam int CMax = 8388607;
    localparam int CMin = -8388608;

    stim_row_t directed [$];
    logic [22:0] phase_dist [NumPhases] = '{23'd0, 23'h7FFFFF, 23'd1024, 23'd300, 23'd256, 23'd5000};
    logic [15:0] phase_thr [NumPhases] = '{16'd0, 16'hFFFF, 16'd30000, 16'd66, 16'd1, 16'd20000};
    int phase_len [NumPhases] = '{350, 40, 350, 350, 360, 300};

    initial
    begin
        // default registers are 256 and 66 after reset
        directed = {directed,
                    mk_row(OpDetect, 0, 0, 0, 65535, 1, OUT_FALSE_POS, 0, 0, 1, 0, 0)};
        directed = {directed,
                    mk_row(OpDetect, 5, 5, 5, 66, 1, OUT_DISCARDED, 0, 0, 1, 1, 0)};
        directed = {directed,
                    mk_row(OpDetect, 5, 5, 5, 0, 1, OUT_DISCARDED, 0, 0, 1, 2, 0)};
        directed = {directed,
                    mk_row(OP_STORE, CMax, CMin, 0, 0, 1, OUT_STORED, 0, 0, 1, 2, 1)};
        directed = {directed,
                    mk_row(OP_STORE, CMin, CMax, -1, 65535, 1, OUT_STORED, 1, 0, 1, 2, 2)};
        directed = {directed,
                    mk_row(OP_STORE, 0, 0, 0, 0, 1, OUT_STORED, 2, 0, 1, 2, 3)};
        // just above the threshold, on top of entry 2
        directed = {directed,
                    mk_row(OpDetect, 0, 0, 0, 67, 1, OUT_NEW_MATCH, 2, 1, 1, 2, 3)};
        directed = {directed,
                    mk_row(OpDetect, 1, 0, 0, 100, 1, OUT_DUPLICATE, 2, 1, 1, 2, 3)};
        // distance exactly at the limit still matches
        directed = {directed,
                    mk_row(OpDetect, 256, 0, 0, 100, 1, OUT_DUPLICATE, 2, 1, 1, 2, 3)};
        directed = {directed,
                    mk_row(OpDetect, 257, 0, 0, 100, 1, OUT_FALSE_POS, 2, 1, 2, 2, 3)};
        // opposite corners of the coordinate range
        directed = {directed,
                    mk_row(OpDetect, CMax, CMin, 0, 65535, 1, OUT_NEW_MATCH, 0, 2, 2, 2, 3)};
        directed = {directed,
                    mk_row(OpDetect, CMin, CMax, -1, 65535, 1, OUT_NEW_MATCH, 1, 3, 2, 2, 3)};
        // tie between entries 2 and 3: the lower index wins
        directed = {directed,
                    mk_row(OP_STORE, 512, 0, 0, 0, 0, OUT_STORED, 0, 0, 0, 0, 0)};
        directed = {directed,
                    mk_row(OpDetect, 256, 0, 0, 9999, 0, OUT_STORED, 0, 0, 0, 0, 0)};
        directed = {directed,
                    mk_row(OpDetect, 0, 256, 256, 65535, 0, OUT_STORED, 0, 0, 0, 0, 0)};
        directed = {directed,
                    mk_row(OpDetect, -1, -1, -1, 65535, 0, OUT_STORED, 0, 0, 0, 0, 0)};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].result);

        for (int ph = 0; ph < NumPhases; ph++)
        begin
            drain();
            write_reg(RegMaxDist, phase_dist[ph]);
            write_reg(RegThreshold, phase_thr[ph]);
            quiet = (ph == NumPhases - 1);
            for (int n = 0; n < phase_len[ph]; n++)
                send_item(random_item(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #30ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
